### rtl/mtg_pkg.sv
// Package for the MT19937 generator: state codes, command codes and fixed constants.
// Used by mtg_unit, the top level and the testbench; depends on nothing.
`default_nettype none
package mtg_pkg;

	localparam int unsigned STATE_DEPTH = 624;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned IDX_W       = 10;

	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(STATE_DEPTH - 1);
	localparam logic [IDX_W-1:0] MID_OFFSET  = IDX_W'(397);
	localparam logic [IDX_W-1:0] MID_WRAP    = IDX_W'(STATE_DEPTH - 397);
	localparam logic [IDX_W-1:0] POS_TWIST   = IDX_W'(STATE_DEPTH);
	localparam logic [IDX_W-1:0] POS_UNSEEDED = IDX_W'(STATE_DEPTH + 1);

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

	localparam logic [1:0] CMD_DRAW = 2'd0;
	localparam logic [1:0] CMD_SEED = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_HI,
		ST_SEED_LO,
		ST_TW_START,
		ST_TW_LOAD,
		ST_TW_NXT,
		ST_TW_FAR,
		ST_DR_ADDR,
		ST_DR_DATA
	} mtg_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] lcg_next;
		logic [WORD_W-1:0] twisted;
		logic [WORD_W-1:0] tempered;
	} mtg_unit_out_t;

endpackage
`default_nettype wire

### rtl/mtg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the generator state words.
`default_nettype none
module mtg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### rtl/mtg_unit.sv
// Shared arithmetic unit: LCG step for seeding, twist recurrence, output tempering.
// Depends on mtg_pkg.
`default_nettype none
module mtg_unit (
	input  wire logic [mtg_pkg::WORD_W-1:0] lcg_x,
	input  wire logic [mtg_pkg::WORD_W-1:0] cur_word,
	input  wire logic [mtg_pkg::WORD_W-1:0] nxt_word,
	input  wire logic [mtg_pkg::WORD_W-1:0] far_word,
	output mtg_pkg::mtg_unit_out_t          res
);
	import mtg_pkg::*;

	logic [WORD_W-1:0] y;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] t3;

	always_comb begin
		// x <- 69069*x + 1 mod 2^32
		res.lcg_next = (lcg_x * LCG_MULT) + WORD_W'(1);

		y = (cur_word & HIGH_BIT) | (nxt_word & LOW_BITS);
		res.twisted = far_word ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);

		t1 = far_word ^ (far_word >> 11);
		t2 = t1 ^ ((t1 << 7) & TEMPER_B);
		t3 = t2 ^ ((t2 << 15) & TEMPER_C);
		res.tempered = t3 ^ (t3 >> 18);
	end
endmodule
`default_nettype wire

### rtl/mersenne_twister_generator.sv
// MT19937 generator (LCG seeding): top level with sequencer, state RAM and shared unit.
// A draw from live state goes through ST_DR_ADDR and ST_DR_DATA and raises word_valid from the
// output register; a seed takes two LCG steps per word (one multiplier); a twist of all 624 words
// takes two RAM reads per word through the single read port, ahead of the draw.
// One item at a time: a new command is taken only in ST_IDLE, after the last word is handed over.
// Reset clears the sequencer and marks the state unseeded; the state RAM is not cleared.
`default_nettype none
module mersenne_twister_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire logic [1:0]                    command,
	input  wire logic [mtg_pkg::WORD_W-1:0]    data_value,
	input  wire logic [mtg_pkg::IDX_W-1:0]     load_index,
	output logic                               word_valid,
	input  wire logic                          word_ready,
	output logic      [mtg_pkg::WORD_W-1:0]    random_word
);
	import mtg_pkg::*;

	mtg_state_t        state_q, state_d;
	logic [IDX_W-1:0]  pos_q;      // next word to draw; 624 = twist due, 625 = unseeded
	logic [IDX_W-1:0]  idx_q;      // word counter shared by seeding and twisting
	logic [WORD_W-1:0] x_q;        // LCG value
	logic [15:0]       hi_q;       // high half captured for the word being seeded
	logic [WORD_W-1:0] cur_q;      // state[k], old value
	logic [WORD_W-1:0] nxt_q;      // state[k+1]
	logic              draw_pend_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	mtg_unit_out_t     unit_res;

	logic              cmd_xfer;
	logic              load_ok;
	logic              out_load;
	logic [IDX_W-1:0]  idx_inc;
	logic [IDX_W-1:0]  nxt_addr;   // (k+1) mod depth
	logic [IDX_W-1:0]  nxt2_addr;  // (k+2) mod depth, issued while writing k
	logic [IDX_W-1:0]  far_addr;   // (k+397) mod depth

	mtg_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STATE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// RAM read data serves as the far word during twist and the drawn word otherwise
	mtg_unit u_unit (
		.lcg_x    (x_q),
		.cur_word (cur_q),
		.nxt_word (nxt_q),
		.far_word (ram_rdata),
		.res      (unit_res)
	);

	assign cmd_ready   = (state_q == ST_IDLE);
	assign cmd_xfer    = cmd_valid && cmd_ready;
	assign load_ok     = (load_index < POS_TWIST);
	assign word_valid  = out_valid_q;
	assign random_word = out_word_q;

	assign idx_inc   = idx_q + IDX_W'(1);
	assign nxt_addr  = (idx_q == LAST_IDX) ? '0 : idx_inc;
	assign nxt2_addr = (idx_inc == LAST_IDX) ? '0 : (idx_q + IDX_W'(2));
	assign far_addr  = (idx_q < MID_WRAP) ? (idx_q + MID_OFFSET) : (idx_q - MID_WRAP);

	// Only hand a new result over once the output register is free
	assign out_load = (state_q == ST_DR_DATA) && (!out_valid_q || word_ready);

	// Next state and RAM port control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = unit_res.twisted;
		ram_raddr = pos_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					case (command)
						CMD_DRAW: begin
							if (pos_q == POS_UNSEEDED) begin
								state_d = ST_SEED_HI;
							end else if (pos_q == POS_TWIST) begin
								state_d = ST_TW_START;
							end else begin
								state_d = ST_DR_ADDR;
							end
						end
						CMD_SEED: state_d = ST_SEED_HI;
						CMD_LOAD: begin
							ram_we    = load_ok;
							ram_waddr = load_index;
							ram_wdata = data_value;
						end
						default: ;
					endcase
				end
			end
			ST_SEED_HI: state_d = ST_SEED_LO;
			ST_SEED_LO: begin
				ram_we    = 1'b1;
				ram_wdata = {hi_q, x_q[31:16]};
				if (idx_q == LAST_IDX) begin
					state_d = draw_pend_q ? ST_TW_START : ST_IDLE;
				end else begin
					state_d = ST_SEED_HI;
				end
			end
			ST_TW_START: begin
				ram_raddr = '0;
				state_d   = ST_TW_LOAD;
			end
			ST_TW_LOAD: begin
				ram_raddr = nxt_addr;
				state_d   = ST_TW_NXT;
			end
			ST_TW_NXT: begin
				ram_raddr = far_addr;
				state_d   = ST_TW_FAR;
			end
			ST_TW_FAR: begin
				// write word k and fetch word k+2 in the same cycle
				ram_we    = 1'b1;
				ram_raddr = nxt2_addr;
				state_d   = (idx_q == LAST_IDX) ? ST_DR_ADDR : ST_TW_NXT;
			end
			ST_DR_ADDR: state_d = ST_DR_DATA;
			ST_DR_DATA: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_UNSEEDED;
			idx_q       <= '0;
			draw_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (word_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (cmd_xfer) begin
						draw_pend_q <= (command == CMD_DRAW);
						if (command == CMD_LOAD && load_ok) begin
							pos_q <= POS_TWIST;
						end
					end
				end
				ST_SEED_LO: begin
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						pos_q <= POS_TWIST;
					end else begin
						idx_q <= idx_inc;
					end
				end
				ST_TW_FAR: begin
					if (idx_q == LAST_IDX) begin
						pos_q <= '0;
					end
					idx_q <= idx_inc;
				end
				ST_DR_DATA: begin
					if (out_load) begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= unit_res.tempered;
		end
		case (state_q)
			ST_IDLE: begin
				// a draw from an unseeded block seeds with the default value
				x_q <= (command == CMD_SEED) ? data_value : DEFAULT_SEED;
			end
			ST_SEED_HI: begin
				hi_q <= x_q[31:16];
				x_q  <= unit_res.lcg_next;
			end
			ST_SEED_LO: x_q <= unit_res.lcg_next;
			ST_TW_LOAD: cur_q <= ram_rdata;
			ST_TW_NXT:  nxt_q <= ram_rdata;
			ST_TW_FAR:  cur_q <= nxt_q;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### verif/mersenne_twister_generator_test.sv
// Self-checking testbench for mersenne_twister_generator (MT19937, LCG seeding).
// Drives draw, seed and load transfers with random idling and checks every tempered word
// against a behavioral model of the generator; depends on rtl/mtg_pkg.sv and the block RTL.
`timescale 1ns / 1ps
module mersenne_twister_generator_test;
	import mtg_pkg::*;

	// Command code with no function in the block; it must be dropped silently.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [WORD_W-1:0] HALF_MASK = 32'hffff_0000;
	localparam int N_DIRECTED   = 23;
	localparam int N_RANDOM     = 1000;
	localparam int MAX_GAP      = 14;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT_WORD = 40;
	localparam int DRAIN_CYCLES = 50;
	// Slowest item: a draw that must seed and then twist, plus both sides' longest idling.
	localparam int CYCLE_LIMIT  = 6_000_000;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [WORD_W-1:0] value;
		logic [IDX_W-1:0]  index;
	} cmd_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	logic [1:0]          command = CMD_DRAW;
	logic [WORD_W-1:0]   data_value = '0;
	logic [IDX_W-1:0]    load_index = '0;
	logic                word_valid;
	logic                word_ready = 1'b0;
	logic [WORD_W-1:0]   random_word;

	// Model of the generator state
	logic [WORD_W-1:0]   pool [STATE_DEPTH];
	logic [IDX_W-1:0]    pool_pos;
	logic [WORD_W-1:0]   expected_words [$];

	int mismatch_count = 0;
	int sent_count = 0;
	int words_seen = 0;

	// Directed stimulus: fields at their extremes, every command, out-of-range loads,
	// the implicit default seed on a first draw, and a load that must not force a twist.
	cmd_row_t directed_rows [N_DIRECTED] = '{
		'{CMD_DRAW,   32'h0000_0000, 10'd0},     // first draw seeds with the default
		'{CMD_DRAW,   32'h0000_0000, 10'd0},
		'{CMD_UNUSED, 32'hffff_ffff, 10'h3ff},   // dropped, no result
		'{CMD_SEED,   32'h0000_0000, 10'd0},
		'{CMD_DRAW,   32'hffff_ffff, 10'h3ff},   // draw ignores the payload
		'{CMD_SEED,   32'hffff_ffff, 10'd0},
		'{CMD_DRAW,   32'h0000_0000, 10'd0},
		'{CMD_DRAW,   32'h0000_0000, 10'd0},
		'{CMD_LOAD,   32'hffff_ffff, 10'd0},
		'{CMD_LOAD,   32'h0000_0000, 10'd623},
		'{CMD_LOAD,   32'h1234_5678, 10'd624},   // just past the end: dropped
		'{CMD_LOAD,   32'ha5a5_a5a5, 10'h3ff},   // top index: dropped
		'{CMD_DRAW,   32'h0000_0000, 10'd0},     // twist after loads
		'{CMD_DRAW,   32'h0000_0000, 10'd0},
		'{CMD_UNUSED, 32'h0000_0000, 10'd0},
		'{CMD_DRAW,   32'h0000_0000, 10'd0},
		'{CMD_SEED,   DEFAULT_SEED,  10'd0},
		'{CMD_LOAD,   32'h5a5a_5a5a, 10'd700},   // dropped: position must stay put
		'{CMD_DRAW,   32'h0000_0000, 10'd0},
		'{CMD_LOAD,   32'h8000_0001, 10'd311},
		'{CMD_DRAW,   32'h0000_0000, 10'd0},
		'{CMD_SEED,   32'h8000_0000, 10'd0},
		'{CMD_DRAW,   32'h0000_0000, 10'd0}
	};

	mersenne_twister_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.data_value  (data_value),
		.load_index  (load_index),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.random_word (random_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------------
	// Generator model
	// ---------------------------------------------------------------------------------

	// Fill the pool from the 69069 congruential sequence, two values per word.
	function automatic void seed_pool(input logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] w;
		x = seed;
		for (int i = 0; i < STATE_DEPTH; i++) begin
			w = x & HALF_MASK;
			x = LCG_MULT * x + 32'd1;
			w = w | ((x & HALF_MASK) >> 16);
			x = LCG_MULT * x + 32'd1;
			pool[i] = w;
		end
		pool_pos = POS_TWIST;
	endfunction

	// Regenerate all words in place; later words see the already updated early ones.
	function automatic void twist_pool();
		logic [WORD_W-1:0] nxt;
		logic [WORD_W-1:0] far;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] v;
		for (int k = 0; k < STATE_DEPTH; k++) begin
			nxt = pool[(k + 1) % STATE_DEPTH];
			far = pool[(k + int'(MID_OFFSET)) % STATE_DEPTH];
			y = (pool[k] & HIGH_BIT) | (nxt & LOW_BITS);
			v = far ^ (y >> 1);
			if (y[0])
				v = v ^ TWIST_MATRIX;
			pool[k] = v;
		end
		pool_pos = '0;
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [WORD_W-1:0] next_word();
		logic [WORD_W-1:0] w;
		if (pool_pos >= POS_TWIST) begin
			if (pool_pos == POS_UNSEEDED)
				seed_pool(DEFAULT_SEED);
			twist_pool();
		end
		w = pool[pool_pos];
		pool_pos = pool_pos + 1'b1;
		return temper(w);
	endfunction

	// Apply one accepted command to the model; a draw queues its expected word.
	function automatic void apply_command(input cmd_row_t row);
		case (row.cmd)
			CMD_DRAW: expected_words.push_back(next_word());
			CMD_SEED: seed_pool(row.value);
			CMD_LOAD: begin
				if (row.index < STATE_DEPTH) begin
					pool[row.index] = row.value;
					pool_pos = POS_TWIST;
				end
			end
			default: ;   // unused code: no state change
		endcase
	endfunction

	// ---------------------------------------------------------------------------------
	// Command side
	// ---------------------------------------------------------------------------------

	// Idle for a random number of cycles, offer the item, hold it until the transfer,
	// then update the model. Every fourth stretch of 32 items runs with no idling.
	task automatic send_command(input cmd_row_t row);
		int gap;
		gap = ((sent_count % 128) >= 96) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid  <= 1'b1;
		command    <= row.cmd;
		data_value <= row.value;
		load_index <= row.index;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		apply_command(row);
		sent_count++;
	endtask

	task automatic send_draws(input int count);
		cmd_row_t row;
		for (int n = 0; n < count; n++) begin
			row.cmd   = CMD_DRAW;
			row.value = $urandom;
			row.index = IDX_W'($urandom_range(0, 1023));
			send_command(row);
		end
	endtask

	initial begin : command_source
		cmd_row_t row;
		int issued;
		int pick;
		int run;

		pool_pos = POS_UNSEEDED;
		for (int i = 0; i < STATE_DEPTH; i++)
			pool[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++)
			send_command(directed_rows[r]);

		// Mostly runs of draws, long enough now and then to use up the whole pool,
		// broken by reseeds, bursts of loads and unused codes.
		issued = 0;
		while (issued < N_RANDOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				run = $urandom_range(1, 64);
				if (run > N_RANDOM - issued)
					run = N_RANDOM - issued;
				send_draws(run);
				issued += run;
			end else if (pick < 65) begin
				run = $urandom_range(300, 700);
				if (run > N_RANDOM - issued)
					run = N_RANDOM - issued;
				send_draws(run);
				issued += run;
			end else if (pick < 77) begin
				row.cmd   = CMD_SEED;
				row.value = $urandom;
				row.index = IDX_W'($urandom_range(0, 1023));
				send_command(row);
				issued++;
			end else if (pick < 92) begin
				run = $urandom_range(1, 4);
				for (int n = 0; n < run; n++) begin
					row.cmd   = CMD_LOAD;
					row.value = $urandom;
					row.index = ($urandom_range(0, 3) == 0)
						? IDX_W'($urandom_range(624, 1023))
						: IDX_W'($urandom_range(0, STATE_DEPTH - 1));
					send_command(row);
				end
				issued += run;
			end else begin
				row.cmd   = CMD_UNUSED;
				row.value = $urandom;
				row.index = IDX_W'($urandom_range(0, 1023));
				send_command(row);
			end
		end
		cmd_valid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------------------------

	// Stall at random before each word; once, hold off long enough that the block
	// backs up and stops taking commands.
	initial begin : word_sink
		int gap;
		bit held;
		logic [WORD_W-1:0] want;

		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && words_seen == HOLD_AT_WORD) begin
				held = 1'b1;
				word_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = ((words_seen % 128) >= 64 && (words_seen % 128) < 96) ? 0
				: $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				word_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			word_ready <= 1'b1;
			@(posedge clk);
			while (!word_valid) @(posedge clk);
			if (expected_words.size() == 0) begin
				$error("random_word: no word expected, actual %h", random_word);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				if (random_word !== want) begin
					$error("random_word: expected %h, actual %h", want, random_word);
					mismatch_count++;
				end
			end
			words_seen++;
		end
	end

	// Stop a hung run.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule
